>>> sv/socp_pkg.sv
package socp_pkg;
   localparam int ValWidth = 24;
   localparam int SumWidth = 52;
   localparam logic signed [ValWidth-1:0] ValMax = 24'sh7FFFFF;

   typedef logic signed [ValWidth-1:0] val_type;
endpackage

>>> sv/socp_if.sv
interface socp_if;
   logic               valid;
   logic               ready;
   socp_pkg::val_type  value;
   logic               last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

>>> sv/second_order_cone_projection.sv
// channel | role   | payload
// req     | sink   | value (Q11.12), last
// rsp     | source | value (Q11.12), last
//
// Loading accepts one element per cycle. On the last element the block runs a
// 26-step square root, then emits elements one at a time through StRead,
// StCalc and StOut; when the vector is scaled, each tail element also passes
// a 50-step divider (one quotient bit a cycle) first. Reset is synchronous
// and clears only state, count and sum. A stalled rsp holds the current
// element and the sequencer, and req stays low until the whole vector is out.
module second_order_cone_projection #(
   parameter int MAX_LEN = 32
) (
   input  logic clock,
   input  logic reset,
   socp_if.sink   req,
   socp_if.source rsp
);
   localparam int IdxW = $clog2(MAX_LEN);
   localparam int CntW = $clog2(MAX_LEN + 1);
   localparam int SW = socp_pkg::SumWidth;
   localparam int NumW = 50;  // mag*alpha*2+s fits

   localparam logic [2:0] StLoad = 3'd0;
   localparam logic [2:0] StSqrt = 3'd1;
   localparam logic [2:0] StRead = 3'd2;
   localparam logic [2:0] StCalc = 3'd3;
   localparam logic [2:0] StDiv  = 3'd4;
   localparam logic [2:0] StOut  = 3'd5;

   localparam logic [1:0] ModeKeep = 2'd0;
   localparam logic [1:0] ModeZero = 2'd1;
   localparam logic [1:0] ModeScale = 2'd2;

   socp_pkg::val_type mem [MAX_LEN];
   socp_pkg::val_type rd_ff;

   logic [2:0] state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [SW-1:0] sum_ff, sum_in;
   socp_pkg::val_type head_ff, head_in;
   logic [1:0] mode_ff, mode_in;
   // isqrt working state
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] root_ff, root_in;
   logic [SW-1:0] bit_ff, bit_in;
   logic [25:0] alpha_ff, alpha_in;
   logic [26:0] den_ff, den_in;
   // divider
   logic [NumW-1:0] num_ff, num_in;
   logic [27:0] drem_ff, drem_in;
   logic [5:0] dstep_ff, dstep_in;
   logic neg_ff, neg_in;
   socp_pkg::val_type ov_ff, ov_in;
   logic ol_ff, ol_in;

   logic wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [IdxW-1:0] rd_addr;

   logic signed [47:0] sq;
   logic signed [47:0] hsq;
   logic [SW-1:0] trial;
   logic [27:0] dsh;
   logic [23:0] mag;
   logic [26:0] alpha_sum;
   logic [50:0] prod;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req.value;
      end
      rd_ff <= mem[rd_addr];
   end

   assign req.ready = (state_ff == StLoad);
   assign rsp.valid = (state_ff == StOut);
   assign rsp.value = ov_ff;
   assign rsp.last = ol_ff;

   assign wr_addr = cnt_ff[IdxW-1:0];
   assign wr_en = req.valid && req.ready && (cnt_ff < CntW'(MAX_LEN));
   assign sq = 48'(req.value) * 48'(req.value);
   assign hsq = 48'(head_ff) * 48'(head_ff);
   assign trial = root_ff + bit_ff;
   assign dsh = {drem_ff[26:0], num_ff[NumW-1]};
   assign mag = rd_ff[23] ? 24'(-rd_ff) : rd_ff;
   assign alpha_sum = 27'(root_ff[25:0]) + 27'(head_ff);

   always_comb begin
      prod = 51'(mag) * 51'(alpha_ff);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      head_in = head_ff;
      mode_in = mode_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      alpha_in = alpha_ff;
      den_in = den_ff;
      num_in = num_ff;
      drem_in = drem_ff;
      dstep_in = dstep_ff;
      neg_in = neg_ff;
      ov_in = ov_ff;
      ol_in = ol_ff;
      rd_addr = idx_ff;
      unique case (state_ff)
         StLoad: begin
            if (req.valid) begin
               if (cnt_ff < CntW'(MAX_LEN)) begin
                  if (cnt_ff == '0) begin
                     head_in = req.value;
                  end else begin
                     sum_in = sum_ff + SW'(unsigned'(sq));
                  end
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req.last) begin
                  rem_in = sum_in;
                  root_in = '0;
                  bit_in = SW'(1) << (SW - 2);
                  state_in = StSqrt;
               end
            end
         end
         StSqrt: begin
            if (bit_ff == '0) begin
               // pick mode once root is known
               if (cnt_ff == CntW'(1)) begin
                  mode_in = ModeKeep;
                  if (head_ff[23]) begin
                     mode_in = ModeZero;
                  end
               end else if (sum_ff <= SW'(unsigned'(hsq))) begin
                  mode_in = head_ff[23] ? ModeZero : ModeKeep;
                  if (head_ff == '0) begin
                     mode_in = ModeKeep;
                  end
               end else begin
                  mode_in = ModeScale;
               end
               alpha_in = 26'(alpha_sum >> 1);
               den_in = 27'({root_ff[25:0], 1'b0});
               idx_in = '0;
               state_in = StRead;
            end else begin
               if (rem_ff >= trial) begin
                  rem_in = rem_ff - trial;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         StRead: begin
            state_in = StCalc;
         end
         StCalc: begin
            ol_in = (CntW'(idx_ff) + 1'b1 == cnt_ff);
            neg_in = rd_ff[23];
            if (mode_ff == ModeZero) begin
               ov_in = '0;
               state_in = StOut;
            end else if (mode_ff == ModeKeep) begin
               ov_in = rd_ff;
               state_in = StOut;
            end else if (idx_ff == '0) begin
               ov_in = (alpha_ff > 26'(socp_pkg::ValMax)) ? socp_pkg::ValMax
                                                         : 24'(alpha_ff);
               state_in = StOut;
            end else begin
               num_in = NumW'(prod << 1) + NumW'(root_ff);
               drem_in = '0;
               dstep_in = '0;
               state_in = StDiv;
            end
         end
         StDiv: begin
            num_in = {num_ff[NumW-2:0], 1'b0};
            if (dsh >= 28'(den_ff)) begin
               drem_in = dsh - 28'(den_ff);
               num_in[0] = 1'b1;
            end else begin
               drem_in = dsh;
            end
            dstep_in = dstep_ff + 1'b1;
            if (dstep_ff == 6'(NumW - 1)) begin
               ov_in = neg_ff ? 24'(-num_in[23:0]) : num_in[23:0];
               state_in = StOut;
            end
         end
         StOut: begin
            if (rsp.ready) begin
               if (ol_ff) begin
                  cnt_in = '0;
                  sum_in = '0;
                  state_in = StLoad;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  rd_addr = idx_in;
                  state_in = StRead;
               end
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
      end
      idx_ff <= idx_in;
      head_ff <= head_in;
      mode_ff <= mode_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      alpha_ff <= alpha_in;
      den_ff <= den_in;
      num_ff <= num_in;
      drem_ff <= drem_in;
      dstep_ff <= dstep_in;
      neg_ff <= neg_in;
      ov_ff <= ov_in;
      ol_ff <= ol_in;
   end
endmodule
